@@ design/inpd_pkg.sv @@
// Package for the inner packet deframer: frame constants, status codes,
// the result struct and the per-byte CRC-8 and CRC-16/ARC update functions.
// No dependencies.
`timescale 1ns / 1ps
package inpd_pkg;

  localparam int unsigned PosW       = 17;
  localparam int unsigned HdrBytes   = 16;
  localparam logic [7:0]  Prefix     = 8'hAA;
  localparam logic [7:0]  Version    = 8'h02;
  localparam logic [7:0]  Crc8Poly   = 8'h07;
  localparam logic [15:0] Crc16Poly  = 16'hA001;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam int unsigned OutDataW   = 96;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_START  = 3'd2;
  localparam logic [2:0] ST_BAD_HDRCRC = 3'd3;
  localparam logic [2:0] ST_BAD_CRC    = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] payload_length;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_group;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [31:0] seq_number;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
  } inpd_result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ Crc8Poly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ Crc16Poly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

endpackage

@@ design/inpd_core.sv @@
// Frame parser core: byte counter, header capture, CRC checks and verdict.
// Builds one result per accepted byte at most. Depends on inpd_pkg.
`timescale 1ns / 1ps
module inpd_core import inpd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output logic         res_valid_o,
  output inpd_result_t res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]  hcrc_q, hcrc_d;
  logic [15:0] fcrc_q, fcrc_d;
  logic [15:0] len_q, len_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  src_q, src_d, dst_q, dst_d, grp_q, grp_d, code_q, code_d;
  logic [7:0]  tlow_q, tlow_d;
  logic        sbad_q, sbad_d, hbad_q, hbad_d, done_q, done_d, match_q, match_d;

  logic [PosW-1:0] body;
  logic            payload;
  logic [2:0]      st;

  always_comb begin
    pos_d   = pos_q;
    hcrc_d  = hcrc_q;
    fcrc_d  = fcrc_q;
    len_d   = len_q;
    seq_d   = seq_q;
    src_d   = src_q;
    dst_d   = dst_q;
    grp_d   = grp_q;
    code_d  = code_q;
    tlow_d  = tlow_q;
    sbad_d  = sbad_q;
    hbad_d  = hbad_q;
    done_d  = done_q;
    match_d = match_q;
    payload = 1'b0;
    st      = ST_OK;
    res_o   = '0;
    res_valid_o = 1'b0;

    if (pos_q == PosW'(0)) sbad_d = (byte_i != Prefix);
    if (pos_q == PosW'(1) && byte_i != Version) sbad_d = 1'b1;
    if (pos_q < PosW'(4)) hcrc_d = crc8_step(hcrc_q, byte_i);
    if (pos_q == PosW'(2)) len_d[7:0] = byte_i;
    if (pos_q == PosW'(3)) len_d[15:8] = byte_i;
    if (pos_q == PosW'(4)) hbad_d = (hcrc_q != byte_i);
    if (pos_q == PosW'(6)) seq_d[7:0] = byte_i;
    if (pos_q == PosW'(7)) seq_d[15:8] = byte_i;
    if (pos_q == PosW'(8)) seq_d[23:16] = byte_i;
    if (pos_q == PosW'(9)) seq_d[31:24] = byte_i;
    if (pos_q == PosW'(12)) src_d = byte_i;
    if (pos_q == PosW'(13)) dst_d = byte_i;
    if (pos_q == PosW'(14)) grp_d = byte_i;
    if (pos_q == PosW'(15)) code_d = byte_i;

    body = PosW'(HdrBytes) + {1'b0, len_d};
    if (pos_q < body) begin
      fcrc_d = crc16_step(fcrc_q, byte_i);
      if (pos_q >= PosW'(HdrBytes) && !sbad_d && !hbad_d) payload = 1'b1;
    end else if (pos_q == body) begin
      tlow_d = byte_i;
    end else if (pos_q == body + PosW'(1)) begin
      match_d = (fcrc_q == {byte_i, tlow_q});
      done_d  = 1'b1;
    end

    if (pos_q != PosMax) pos_d = pos_q + PosW'(1);

    if (pos_q < PosW'(HdrBytes + 1))  st = ST_TOO_SHORT;
    else if (sbad_d)                  st = ST_BAD_START;
    else if (hbad_d)                  st = ST_BAD_HDRCRC;
    else if (!done_d)                 st = ST_TOO_SHORT;
    else if (!match_d)                st = ST_BAD_CRC;
    else                              st = ST_OK;

    if (last_i) begin
      res_valid_o        = accept_i;
      res_o.result_kind  = KIND_VERDICT;
      res_o.status       = st;
      if (st == ST_OK) begin
        res_o.seq_number     = seq_d;
        res_o.source_addr    = src_d;
        res_o.dest_addr      = dst_d;
        res_o.cmd_group      = grp_d;
        res_o.cmd_code       = code_d;
        res_o.payload_length = len_d;
      end
      // return all state to reset for the next buffer
      pos_d   = '0;
      hcrc_d  = '0;
      fcrc_d  = '0;
      len_d   = '0;
      seq_d   = '0;
      src_d   = '0;
      dst_d   = '0;
      grp_d   = '0;
      code_d  = '0;
      tlow_d  = '0;
      sbad_d  = 1'b0;
      hbad_d  = 1'b0;
      done_d  = 1'b0;
      match_d = 1'b0;
    end else if (payload) begin
      res_valid_o        = accept_i;
      res_o.result_kind  = KIND_PAYLOAD;
      res_o.payload_byte = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hcrc_q  <= '0;
      fcrc_q  <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      grp_q   <= '0;
      code_q  <= '0;
      tlow_q  <= '0;
      sbad_q  <= 1'b0;
      hbad_q  <= 1'b0;
      done_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      hcrc_q  <= hcrc_d;
      fcrc_q  <= fcrc_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      grp_q   <= grp_d;
      code_q  <= code_d;
      tlow_q  <= tlow_d;
      sbad_q  <= sbad_d;
      hbad_q  <= hbad_d;
      done_q  <= done_d;
      match_q <= match_d;
    end
  end

endmodule

@@ design/inner_packet_deframer.sv @@
// Inner packet deframer top level: stream ports, output register and skid stage.
// Each result is registered in the output stage, via the skid stage when stalled.
// Throughput: one byte per cycle, but only while the skid stage is empty.
// Reset: rst_ni (async, active low) clears parser state and both output valid flags.
// Depends on inpd_pkg and inpd_core.
`timescale 1ns / 1ps
module inner_packet_deframer import inpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] in_byte
  input  logic                s_axis_tlast_i,   // end_of_buffer
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] payload_byte, [10:8] status, [42:11] seq_number, [50:43] source_addr,
  // [58:51] dest_addr, [66:59] cmd_group, [74:67] cmd_code,
  // [90:75] payload_length, [95:91] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o    // result_kind
);

  inpd_result_t res, out_q, out_d, skid_q, skid_d;
  logic         res_vld, out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic         accept, pop;

  assign s_axis_tready_o = !skid_vld_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign pop    = out_vld_q && m_axis_tready_i;

  inpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_d     = res;
        skid_vld_d = res_vld;
      end else begin
        out_d     = res;
        out_vld_d = res_vld;
      end
    end else if (res_vld) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.result_kind;
  assign m_axis_tdata_o  = {5'b0, out_q.payload_length, out_q.cmd_code, out_q.cmd_group,
                            out_q.dest_addr, out_q.source_addr, out_q.seq_number,
                            out_q.status, out_q.payload_byte};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for inner_packet_deframer: frames, broken frames and noise
// buffers go in on the byte stream; payload bytes and verdicts are checked in order.
// Depends on inpd_pkg and the deframer RTL.
`timescale 1ns / 1ps
module tb;
  import inpd_pkg::*;

  class deframe_tracker;
    logic [PosW-1:0] pos;
    logic [7:0]      hdr_crc;
    logic [15:0]     body_crc;
    logic [15:0]     plen;
    logic [31:0]     seq;
    logic [7:0]      src, dst, grp, code, trl_low;
    bit              start_bad, hdr_bad, done, crc_ok;
    inpd_result_t    payloads_and_verdicts[$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      hdr_crc = '0;
      body_crc = '0;
      plen = '0;
      seq = '0;
      src = '0;
      dst = '0;
      grp = '0;
      code = '0;
      trl_low = '0;
      start_bad = 0;
      hdr_bad = 0;
      done = 0;
      crc_ok = 0;
    endfunction

    static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? Crc8Poly : 8'h00);
      return r;
    endfunction

    static function logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? Crc16Poly : 16'h0000);
      return r;
    endfunction

    function void parse_byte(logic [7:0] b, logic last);
      inpd_result_t r;
      int unsigned  p;
      int unsigned  body;
      bit           pay;
      p = int'(pos);
      pay = 0;
      r = '0;
      if (p == 0) start_bad = (b != Prefix);
      if (p == 1 && b != Version) start_bad = 1;
      if (p < 4) hdr_crc = crc8_next(hdr_crc, b);
      if (p == 2) plen[7:0] = b;
      if (p == 3) plen[15:8] = b;
      if (p == 4) hdr_bad = (hdr_crc != b);
      if (p >= 6 && p <= 9) seq = seq | ({24'h0, b} << (8 * (p - 6)));
      if (p == 12) src = b;
      if (p == 13) dst = b;
      if (p == 14) grp = b;
      if (p == 15) code = b;
      body = HdrBytes + plen;
      if (p < body) begin
        body_crc = crc16_next(body_crc, b);
        if (p >= HdrBytes && !start_bad && !hdr_bad) pay = 1;
      end else if (p == body) begin
        trl_low = b;
      end else if (p == body + 1) begin
        crc_ok = (body_crc == {b, trl_low});
        done = 1;
      end
      if (pos != PosMax) pos = pos + 1'b1;
      if (last) begin
        r.result_kind = KIND_VERDICT;
        if (pos < HdrBytes + 2) r.status = ST_TOO_SHORT;
        else if (start_bad) r.status = ST_BAD_START;
        else if (hdr_bad) r.status = ST_BAD_HDRCRC;
        else if (!done) r.status = ST_TOO_SHORT;
        else if (!crc_ok) r.status = ST_BAD_CRC;
        else r.status = ST_OK;
        if (r.status == ST_OK) begin
          r.seq_number = seq;
          r.source_addr = src;
          r.dest_addr = dst;
          r.cmd_group = grp;
          r.cmd_code = code;
          r.payload_length = plen;
        end
        clear();
        payloads_and_verdicts = {payloads_and_verdicts, r};
      end else if (pay) begin
        r.result_kind = KIND_PAYLOAD;
        r.payload_byte = b;
        payloads_and_verdicts = {payloads_and_verdicts, r};
      end
    endfunction

    function void match_result(logic [OutDataW-1:0] data, logic kind);
      inpd_result_t want;
      inpd_result_t got;
      string        diffs;
      diffs = "";
      got = {kind, data[90:0]};
      if (payloads_and_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: kind %0d data %h", kind, data);
        return;
      end
      want = payloads_and_verdicts.pop_front();
      if (got.result_kind !== want.result_kind) diffs = {diffs, " kind"};
      if (got.payload_byte !== want.payload_byte) diffs = {diffs, " payload_byte"};
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.seq_number !== want.seq_number) diffs = {diffs, " seq_number"};
      if (got.source_addr !== want.source_addr) diffs = {diffs, " source_addr"};
      if (got.dest_addr !== want.dest_addr) diffs = {diffs, " dest_addr"};
      if (got.cmd_group !== want.cmd_group) diffs = {diffs, " cmd_group"};
      if (got.cmd_code !== want.cmd_code) diffs = {diffs, " cmd_code"};
      if (got.payload_length !== want.payload_length) diffs = {diffs, " payload_length"};
      if (diffs != "") begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch in%s", diffs);
          $display({"  expected kind %0d byte %h status %0d seq %h src %h dst %h",
                    " grp %h cmd %h len %h"},
                   want.result_kind, want.payload_byte, want.status, want.seq_number,
                   want.source_addr, want.dest_addr, want.cmd_group, want.cmd_code,
                   want.payload_length);
          $display({"  actual   kind %0d byte %h status %0d seq %h src %h dst %h",
                    " grp %h cmd %h len %h"},
                   got.result_kind, got.payload_byte, got.status, got.seq_number,
                   got.source_addr, got.dest_addr, got.cmd_group, got.cmd_code,
                   got.payload_length);
        end
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 3000000;

  logic                clk_i;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  deframe_tracker sb;
  bit             idle_en = 1'b1;
  int unsigned    cycles = 0;
  logic [7:0]     rx_buffer[$];

  inner_packet_deframer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("inner_packet_deframer regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) sb.match_result(m_tdata, m_tuser);
    m_tready <= !(idle_en && $urandom_range(99) < 18);
  end

  function automatic void put_byte(input logic [7:0] b);
    rx_buffer = {rx_buffer, b};
  endfunction

  function automatic void load_frame(input logic [15:0] len, input logic [31:0] seq_val,
                                     input logic [7:0] src, input logic [7:0] dst,
                                     input logic [7:0] grp, input logic [7:0] code);
    logic [7:0]  hc;
    logic [15:0] fc;
    rx_buffer.delete();
    put_byte(Prefix);
    put_byte(Version);
    put_byte(len[7:0]);
    put_byte(len[15:8]);
    hc = 8'h00;
    for (int i = 0; i < 4; i++) hc = deframe_tracker::crc8_next(hc, rx_buffer[i]);
    put_byte(hc);
    put_byte(8'($urandom_range(255)));
    for (int i = 0; i < 4; i++) put_byte(seq_val[8*i +: 8]);
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    put_byte(src);
    put_byte(dst);
    put_byte(grp);
    put_byte(code);
    for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
    fc = 16'h0000;
    foreach (rx_buffer[i]) fc = deframe_tracker::crc16_next(fc, rx_buffer[i]);
    put_byte(fc[7:0]);
    put_byte(fc[15:8]);
  endfunction

  function automatic void corrupt_byte(input int idx);
    rx_buffer[idx] = rx_buffer[idx] ^ 8'($urandom_range(255, 1));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk_i); while (!s_tready);
    sb.parse_byte(b, last);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < rx_buffer.size(); i++) send_byte(rx_buffer[i], i == rx_buffer.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.payloads_and_verdicts.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned frame_no;
    sb = new();
    random_bytes = 0;
    frame_no = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // clean frames at the field extremes
    load_frame(16'h0000, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_buffer();
    load_frame(16'h0003, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_buffer();
    // bad prefix, bad version, bad header crc, bad trailer crc
    load_frame(16'h0002, $urandom, 8'h12, 8'h34, 8'h56, 8'h78);
    corrupt_byte(0);
    send_buffer();
    load_frame(16'h0001, $urandom, 8'h01, 8'h02, 8'h03, 8'h04);
    corrupt_byte(1);
    send_buffer();
    load_frame(16'h0002, $urandom, 8'h80, 8'h7F, 8'hA5, 8'h5A);
    corrupt_byte(4);
    send_buffer();
    load_frame(16'h0004, $urandom, 8'h11, 8'h22, 8'h33, 8'h44);
    corrupt_byte(rx_buffer.size() - 2);
    send_buffer();
    // short buffer, payload byte carrying the end mark, missing trailer byte
    load_frame(16'h0000, $urandom, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (rx_buffer.size() - 10) void'(rx_buffer.pop_back());
    send_buffer();
    load_frame(16'h0005, $urandom, 8'h09, 8'h08, 8'h07, 8'h06);
    repeat (rx_buffer.size() - 19) void'(rx_buffer.pop_back());
    send_buffer();
    load_frame(16'h0002, $urandom, 8'hC0, 8'hDE, 8'h01, 8'h02);
    void'(rx_buffer.pop_back());
    send_buffer();
    // trailing bytes past the frame, then a one-byte buffer
    load_frame(16'h0001, $urandom, 8'hAB, 8'hCD, 8'hEF, 8'h10);
    repeat (3) put_byte(8'($urandom_range(255)));
    send_buffer();
    rx_buffer.delete();
    put_byte(Prefix);
    send_buffer();
    wait_drained();

    while (random_bytes < 560) begin
      frame_no++;
      idle_en = !(frame_no >= 8 && frame_no < 18);
      if ($urandom_range(99) < 75) begin
        load_frame(16'(($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(48)),
                   $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
        case ($urandom_range(11))
          0: corrupt_byte(0);
          1: corrupt_byte(1);
          2: corrupt_byte(4);
          3: corrupt_byte(2 + $urandom_range(1));
          4: corrupt_byte(rx_buffer.size() - 1 - $urandom_range(1));
          5: corrupt_byte($urandom_range(rx_buffer.size() - 3, 5));
          6: repeat ($urandom_range(rx_buffer.size() - 1, 1)) void'(rx_buffer.pop_back());
          7: repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
          default: ;
        endcase
      end else begin
        rx_buffer.delete();
        repeat ($urandom_range(24, 1)) put_byte(8'($urandom_range(255)));
        if ($urandom_range(1)) begin
          rx_buffer[0] = Prefix;
          if (rx_buffer.size() > 1) rx_buffer[1] = Version;
        end
      end
      random_bytes += rx_buffer.size();
      send_buffer();
    end

    idle_en = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("inner_packet_deframer regression: pass");
    end else begin
      $display("inner_packet_deframer regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/inpd_pkg.sv
design/inpd_core.sv
design/inner_packet_deframer.sv
tb/tb.sv
